[design/nnmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest neighbor match counter package
// Shared types, opcodes and constants of the nearest neighbor match counter.
// ----------------------------------------------------------------------------
package nnmc_pkg;

    localparam int unsigned MAP_DEPTH_DEF = 1024;

    localparam int unsigned COORD_W   = 24;
    localparam int unsigned RADIUS_W  = 23;
    localparam int unsigned SQ_W      = 2 * COORD_W;
    localparam int unsigned DIST_W    = SQ_W + 1;
    localparam int unsigned RADSQ_W   = 2 * RADIUS_W;
    localparam int unsigned COUNT_W   = 16;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = RADIUS_W'(1024);
    localparam logic [DIST_W-1:0]   DIST_ALL_ONES = {DIST_W{1'b1}};
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = {COUNT_W{1'b1}};

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_query;
    } t_in_item;

    typedef struct packed {
        logic               matched;
        logic [DIST_W-1:0]  nearest_dist_sq;
        logic [COUNT_W-1:0] match_total;
        logic               scan_done;
    } t_out_item;

    // Tag that travels with each map point through the distance pipeline.
    typedef struct packed {
        logic vld;
        logic last;
    } t_scan_tag;

endpackage

[design/nearest_neighbor_match_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest neighbor match counter
// Brute force 2D nearest neighbor search over a map point store with a
// running, saturating count of queries that fall within the match radius.
// ----------------------------------------------------------------------------
// Load, clear and unused ops produce no result.
// A query streams every stored point through the map RAM and the distance
// pipeline (none with an empty store); no other item is taken meanwhile.
// One stored point is read per cycle; a full output register stalls the result.
// Reset (synchronous, active low) empties the store, clears the match total
// and sets the radius to 1024; the map memory itself is not cleared.
// ----------------------------------------------------------------------------
module nearest_neighbor_match_counter #(
    parameter int unsigned MAP_DEPTH = nnmc_pkg::MAP_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nnmc_pkg::RADIUS_W-1:0]      i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  nnmc_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output nnmc_pkg::t_out_item                o_out_item
);
    import nnmc_pkg::*;

    // The address covers the store; the fill count can also hold the depth.
    localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int unsigned FW = $clog2(MAP_DEPTH + 1);
    localparam int unsigned MW = 2 * COORD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                    r_state;
    logic [FW-1:0]             r_fill;
    logic [COUNT_W-1:0]        r_count;
    logic [RADIUS_W-1:0]       r_radius;
    logic [RADSQ_W-1:0]        r_radius_sq;
    logic [AW-1:0]             r_rd_addr;
    logic                      r_issuing;
    t_scan_tag                 r_rd_tag;
    logic signed [COORD_W-1:0] r_qx;
    logic signed [COORD_W-1:0] r_qy;
    logic                      r_last;
    logic [DIST_W-1:0]         r_best;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      in_xfer;
    logic                      ram_we;
    logic                      ram_re;
    logic                      rd_last;
    logic [MW-1:0]             ram_rdata;
    logic [DIST_W-1:0]         pt_dist;
    t_scan_tag                 dist_tag;
    logic [DIST_W-1:0]         n_best;
    logic                      hit;
    logic [COUNT_W-1:0]        n_count;
    logic                      out_free;

    // ------------------------------------------------------------------
    // Handshake and memory control. Loads write only while idle and the
    // scan reads only in its own state, so the two never touch the
    // memory in the same cycle.
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign ram_we     = in_xfer && (i_in_item.op == OP_LOAD) && (r_fill < FW'(MAP_DEPTH));
    assign ram_re     = (r_state == S_SCAN) && r_issuing;
    assign rd_last    = (FW'(r_rd_addr) == (r_fill - FW'(1)));
    assign out_free   = !r_out_valid || i_out_ready;

    nnmc_ram #(
        .WIDTH (MW),
        .DEPTH (MAP_DEPTH),
        .AW    (AW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata ({i_in_item.point_x, i_in_item.point_y}),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    nnmc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_mx    (ram_rdata[MW-1:COORD_W]),
        .i_my    (ram_rdata[COORD_W-1:0]),
        .i_tag   (r_rd_tag),
        .o_dist  (pt_dist),
        .o_tag   (dist_tag)
    );

    // Running minimum; a tie keeps the earlier value, which is the same.
    always_comb begin
        n_best = r_best;
        if (dist_tag.vld && (pt_dist < r_best)) begin
            n_best = pt_dist;
        end
    end

    // A query matches only against a non-empty store.
    assign hit     = (r_fill != '0) && (r_best <= {{(DIST_W - RADSQ_W){1'b0}}, r_radius_sq});
    assign n_count = (hit && (r_count != COUNT_MAX)) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        // The squared radius is registered from the radius register and follows it in the next cycle.
        r_radius_sq <= r_radius * r_radius;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_radius    <= RADIUS_RESET;
            r_issuing   <= 1'b0;
            r_rd_tag    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            // A finishing query refills the register in the same cycle.
            if (o_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            r_rd_tag <= '{vld: ram_re, last: rd_last};

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_in_item.op)
                            OP_LOAD: begin
                                if (ram_we) begin
                                    r_fill <= r_fill + 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_fill <= '0;
                            end
                            OP_QUERY: begin
                                r_qx      <= i_in_item.point_x;
                                r_qy      <= i_in_item.point_y;
                                r_last    <= i_in_item.last_query;
                                r_best    <= DIST_ALL_ONES;
                                r_rd_addr <= '0;
                                if (r_fill == '0) begin
                                    r_state <= S_FINISH;
                                end else begin
                                    r_issuing <= 1'b1;
                                    r_state   <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_issuing) begin
                        if (rd_last) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_rd_addr <= r_rd_addr + 1'b1;
                        end
                    end
                    r_best <= n_best;
                    if (dist_tag.vld && dist_tag.last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // The result waits here until the output register is free.
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.matched         <= hit;
                        r_out.nearest_dist_sq <= r_best;
                        r_out.match_total     <= n_count;
                        r_out.scan_done       <= r_last;
                        r_count               <= r_last ? '0 : n_count;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAP_DEPTH))
        else $error("map fill count exceeds the store depth");

    a_ram_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("map store written and read in the same cycle");

    a_dist_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_tag.vld |-> (r_state == S_SCAN))
        else $error("distance arrived outside a scan");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && !out_free |=> (r_state == S_FINISH))
        else $error("result left the finish state over a full output register");

    a_match_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.matched |-> (o_out_item.nearest_dist_sq != DIST_ALL_ONES))
        else $error("match reported with the empty store distance");

endmodule

[design/nnmc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single port write, single port read RAM
// Synchronous write and registered read.
// ----------------------------------------------------------------------------
module nnmc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/nnmc_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squared distance pipeline
// Three stage pipeline: absolute differences, squares, then their sum.
// ----------------------------------------------------------------------------
module nnmc_dist (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [nnmc_pkg::COORD_W-1:0] i_qx,
    input  logic signed [nnmc_pkg::COORD_W-1:0] i_qy,
    input  logic signed [nnmc_pkg::COORD_W-1:0] i_mx,
    input  logic signed [nnmc_pkg::COORD_W-1:0] i_my,
    input  nnmc_pkg::t_scan_tag                i_tag,
    output logic [nnmc_pkg::DIST_W-1:0]        o_dist,
    output nnmc_pkg::t_scan_tag                o_tag
);
    import nnmc_pkg::*;

    logic [COORD_W:0]   dx;
    logic [COORD_W:0]   dy;
    logic [COORD_W:0]   n_adx;
    logic [COORD_W:0]   n_ady;
    logic [COORD_W-1:0] r_adx;
    logic [COORD_W-1:0] r_ady;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;
    logic [DIST_W-1:0]  r_sum;
    t_scan_tag          r_tag1;
    t_scan_tag          r_tag2;
    t_scan_tag          r_tag3;

    // The magnitude of a 25 bit difference of two 24 bit values fits in 24 bits.
    always_comb begin
        dx    = {i_qx[COORD_W-1], i_qx} - {i_mx[COORD_W-1], i_mx};
        dy    = {i_qy[COORD_W-1], i_qy} - {i_my[COORD_W-1], i_my};
        n_adx = dx[COORD_W] ? (~dx + 1'b1) : dx;
        n_ady = dy[COORD_W] ? (~dy + 1'b1) : dy;
    end

    always_ff @(posedge i_clk) begin
        r_adx <= n_adx[COORD_W-1:0];
        r_ady <= n_ady[COORD_W-1:0];
        r_sqx <= r_adx * r_adx;
        r_sqy <= r_ady * r_ady;
        r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_dist = r_sum;
    assign o_tag  = r_tag3;

endmodule

[tb/sv/nearest_neighbor_match_counter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest neighbor match counter testbench
// Drives map loads, clears and queries through the valid/ready input channel
// and checks every query result against a shadow map kept in the testbench.
// Directed tests cover the reset state, coordinate extremes, radius limits
// and output back-pressure.
// These are followed by random scans.
// ----------------------------------------------------------------------------
module nearest_neighbor_match_counter_test;

    import nnmc_pkg::*;

    localparam int unsigned MAP_DEPTH = MAP_DEPTH_DEF;

    // Op value 3 has no meaning in the block and must be dropped silently.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [RADIUS_W-1:0]       RADIUS_MAX = {RADIUS_W{1'b1}};

    // Loads and clears leave the block idle right after their transfer, so a short
    // tail after the last query result is enough to reach an idle block.
    localparam int DRAIN_TAIL = 8;

    localparam int RANDOM_ITEMS = 350;

    // About 400 items; even if every query scanned a full store with the
    // longest idle gaps on both sides, this leaves several times that margin.
    localparam longint RUN_LIMIT_NS = 40_000_000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [RADIUS_W-1:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Shadow copy of the block state, updated at each input transfer and radius write.
    logic signed [COORD_W-1:0] shadow_x [MAP_DEPTH];
    logic signed [COORD_W-1:0] shadow_y [MAP_DEPTH];
    int unsigned               shadow_fill = 0;
    logic [COUNT_W-1:0]        shadow_total = '0;
    logic [RADIUS_W-1:0]       shadow_radius = RADIUS_RESET;

    // Query results that the block still owes us, oldest first.
    t_out_item results_due [$];

    int  mismatch_count = 0;
    bit  idle_off = 1'b0;      // when set, neither side inserts idle cycles
    int  hold_cycles = 0;      // a request for a long output stall

    always #5 clk = ~clk;

    nearest_neighbor_match_counter #(
        .MAP_DEPTH(MAP_DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------

    // Exact squared Euclidean distance; the sum needs 49 bits at most.
    function automatic longint unsigned dist_sq(
        logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
        logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return longint'(dx * dx + dy * dy);
    endfunction

    // Applies one accepted item to the shadow map. A query produces the
    // result the block has to return: nearest distance over every stored
    // point, match against the squared radius, and the saturating total.
    task automatic predict_nearest(input t_in_item it);
        t_out_item         res;
        longint unsigned   best;
        longint unsigned   d;
        longint unsigned   radius_sq;
        case (it.op)
            OP_LOAD: begin
                // A full store silently drops the point.
                if (shadow_fill < MAP_DEPTH) begin
                    shadow_x[shadow_fill] = it.point_x;
                    shadow_y[shadow_fill] = it.point_y;
                    shadow_fill++;
                end
            end
            OP_CLEAR: begin
                // Only the store empties; the running total is kept.
                shadow_fill = 0;
            end
            OP_QUERY: begin
                best = DIST_ALL_ONES;
                radius_sq = longint'(shadow_radius) * longint'(shadow_radius);
                for (int i = 0; i < shadow_fill; i++) begin
                    d = dist_sq(it.point_x, it.point_y, shadow_x[i], shadow_y[i]);
                    if (d < best) begin
                        best = d;
                    end
                end
                // An empty store reports the sentinel and never matches.
                res.matched = (shadow_fill > 0) && (best <= radius_sq);
                if (res.matched && shadow_total != COUNT_MAX) begin
                    shadow_total++;
                end
                res.nearest_dist_sq = best[DIST_W-1:0];
                res.match_total     = shadow_total;
                res.scan_done       = it.last_query;
                results_due = {results_due, res};
                // The total of a finished scan is reported before it clears.
                if (it.last_query) begin
                    shadow_total = '0;
                end
            end
            default: begin
                // The spare op is ignored entirely.
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checking: every output transfer is compared with the oldest
    // result still owed. Only the first ten failures are printed.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_result
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: matched=%0b dist=%h total=%0d done=%0b",
                             o_out_item.matched, o_out_item.nearest_dist_sq,
                             o_out_item.match_total, o_out_item.scan_done);
                end
            end else begin
                want = results_due.pop_front();
                if (o_out_item.matched !== want.matched ||
                    o_out_item.nearest_dist_sq !== want.nearest_dist_sq ||
                    o_out_item.match_total !== want.match_total ||
                    o_out_item.scan_done !== want.scan_done) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result mismatch at %0t ns:", $time);
                        $display("  expected matched=%0b dist=%h total=%0d done=%0b",
                                 want.matched, want.nearest_dist_sq,
                                 want.match_total, want.scan_done);
                        $display("  actual   matched=%0b dist=%h total=%0d done=%0b",
                                 o_out_item.matched, o_out_item.nearest_dist_sq,
                                 o_out_item.match_total, o_out_item.scan_done);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Before each transfer it stalls for a random number of
    // cycles; a test may also ask for one long stall through hold_cycles,
    // which is counted down here while the sender keeps offering items.
    // ------------------------------------------------------------------------
    initial begin : result_receiver
        int stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = idle_off ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(o_out_valid && out_ready) && hold_cycles == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_in_item make_item(logic [1:0] op,
                                           logic signed [COORD_W-1:0] x,
                                           logic signed [COORD_W-1:0] y,
                                           logic last);
        t_in_item it;
        it.op         = op;
        it.point_x    = x;
        it.point_y    = y;
        it.last_query = last;
        return it;
    endfunction

    // Offers one item after a random gap and returns once it is transferred.
    // Valid is left high so that back-to-back items keep it asserted.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!o_in_ready);
        predict_nearest(it);
    endtask

    // Stops offering and waits until every owed result has come back, then
    // lets any trailing load or clear finish.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // The radius may only change on an idle block.
    task automatic write_radius(input logic [RADIUS_W-1:0] radius);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= radius;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_radius = radius;
    endtask

    // A point near the given one, offsets of a few radii at the reset value.
    function automatic logic signed [COORD_W-1:0] near_coord(
        logic signed [COORD_W-1:0] base);
        int v;
        v = int'(base) + $urandom_range(0, 6000) - 3000;
        return v[COORD_W-1:0];
    endfunction

    // A cluster center that keeps near_coord clear of wrap-around.
    function automatic logic signed [COORD_W-1:0] center_coord();
        int v;
        v = $urandom_range(0, (1 << COORD_W) - 8192) - (1 << (COORD_W - 1)) + 4096;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [RADIUS_W-1:0] pick_radius();
        case ($urandom_range(0, 3))
            0:       return RADIUS_W'(1);
            1:       return RADIUS_MAX;
            2:       return RADIUS_W'($urandom_range(1, 8192));
            default: return RADIUS_W'($urandom_range(1, RADIUS_MAX));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset state: an empty store answers with the sentinel distance, and
    // the spare op as well as last_query on non-queries are ignored.
    task automatic test_empty_and_ignored();
        send_item(make_item(OP_QUERY, COORD_MAX, COORD_MIN, 1'b0));
        send_item(make_item(OP_SPARE, COORD_MIN, COORD_MAX, 1'b1));
        send_item(make_item(OP_LOAD, 24'sd0, 24'sd0, 1'b1));
        send_item(make_item(OP_CLEAR, COORD_MAX, COORD_MAX, 1'b1));
        send_item(make_item(OP_QUERY, 24'sd0, 24'sd0, 1'b1));
    endtask

    // Boundaries of the default radius, coordinate extremes and equal
    // distances to two stored points.
    task automatic test_nearest_extremes();
        send_item(make_item(OP_LOAD, 24'sd0, 24'sd0, 1'b0));
        send_item(make_item(OP_QUERY, 24'sd1024, 24'sd0, 1'b0));   // exactly on radius
        send_item(make_item(OP_QUERY, 24'sd1025, 24'sd0, 1'b0));   // just outside
        send_item(make_item(OP_QUERY, 24'sd724, -24'sd724, 1'b0)); // diagonal, inside
        send_item(make_item(OP_QUERY, COORD_MIN, COORD_MIN, 1'b0));
        send_item(make_item(OP_LOAD, COORD_MAX, COORD_MAX, 1'b0));
        send_item(make_item(OP_LOAD, COORD_MIN, COORD_MIN, 1'b0));
        send_item(make_item(OP_QUERY, COORD_MIN, COORD_MIN, 1'b0));
        send_item(make_item(OP_QUERY, COORD_MAX, COORD_MIN, 1'b1));
        // Largest possible distance: opposite corners with one stored point.
        send_item(make_item(OP_CLEAR, 24'sd0, 24'sd0, 1'b0));
        send_item(make_item(OP_LOAD, COORD_MAX, COORD_MAX, 1'b0));
        send_item(make_item(OP_QUERY, COORD_MIN, COORD_MIN, 1'b0));
        // Two stored points at the same distance from the query.
        send_item(make_item(OP_CLEAR, 24'sd0, 24'sd0, 1'b0));
        send_item(make_item(OP_LOAD, 24'sd10, 24'sd0, 1'b0));
        send_item(make_item(OP_LOAD, -24'sd10, 24'sd0, 1'b0));
        send_item(make_item(OP_QUERY, 24'sd0, 24'sd0, 1'b1));
    endtask

    // Smallest, largest and zero radius, each right at its boundary.
    task automatic test_radius_limits();
        write_radius(RADIUS_W'(1));
        send_item(make_item(OP_CLEAR, 24'sd0, 24'sd0, 1'b0));
        send_item(make_item(OP_LOAD, 24'sd0, 24'sd0, 1'b0));
        send_item(make_item(OP_QUERY, 24'sd1, 24'sd0, 1'b0));
        send_item(make_item(OP_QUERY, 24'sd1, 24'sd1, 1'b1));
        // A zero radius still matches an exact coincidence.
        write_radius(RADIUS_W'(0));
        send_item(make_item(OP_QUERY, 24'sd0, 24'sd0, 1'b0));
        send_item(make_item(OP_QUERY, 24'sd0, -24'sd1, 1'b1));
        write_radius(RADIUS_MAX);
        send_item(make_item(OP_QUERY, COORD_MAX, 24'sd0, 1'b0));
        send_item(make_item(OP_QUERY, COORD_MAX, 24'sd1, 1'b0));
        send_item(make_item(OP_QUERY, COORD_MIN, COORD_MIN, 1'b1));
        write_radius(RADIUS_RESET);
    endtask

    // The receiver stalls for a long stretch while queries keep coming, so
    // the block fills up and holds its input; then the sender waits for all
    // owed results before going on.
    task automatic test_output_stall();
        send_item(make_item(OP_CLEAR, 24'sd0, 24'sd0, 1'b0));
        for (int i = 0; i < 3; i++) begin
            send_item(make_item(OP_LOAD, near_coord(24'sd0), near_coord(24'sd0), 1'b0));
        end
        hold_cycles = 300;
        for (int i = 0; i < 8; i++) begin
            send_item(make_item(OP_QUERY, near_coord(24'sd0), near_coord(24'sd0),
                                1'(i == 7)));
        end
        wait_drained();
    endtask

    // Random scans: optional radius write and clear, a map point cluster, then
    // queries near and far from it with last_query on the final one. Some scans
    // are left open, some run with no idle cycles, and spare ops are mixed in.
    task automatic test_random_scans();
        int counted;
        int n_load;
        int n_query;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        bit leave_open;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            idle_off = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) begin
                write_radius(pick_radius());
            end
            if ($urandom_range(0, 1) == 0) begin
                send_item(make_item(OP_CLEAR, 24'($urandom), 24'($urandom), 1'($urandom)));
                counted++;
            end
            cx = center_coord();
            cy = center_coord();
            n_load = $urandom_range(0, 12);
            for (int i = 0; i < n_load; i++) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_item(make_item(OP_LOAD, 24'($urandom), 24'($urandom),
                                        1'($urandom)));
                end else begin
                    send_item(make_item(OP_LOAD, near_coord(cx), near_coord(cy),
                                        1'($urandom)));
                end
                counted++;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_item(make_item(OP_SPARE, 24'($urandom), 24'($urandom), 1'($urandom)));
            end
            n_query = $urandom_range(1, 8);
            leave_open = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < n_query; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(make_item(OP_QUERY, 24'($urandom), 24'($urandom),
                                        1'(i == n_query - 1 && !leave_open)));
                end else begin
                    send_item(make_item(OP_QUERY, near_coord(cx), near_coord(cy),
                                        1'(i == n_query - 1 && !leave_open)));
                end
                counted++;
            end
        end
        idle_off = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : run_tests
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_ignored();
        test_nearest_extremes();
        test_radius_limits();
        test_output_stall();
        test_random_scans();

        wait_drained();
        if (results_due.size() != 0) begin
            mismatch_count += results_due.size();
        end
        if (mismatch_count == 0) begin
            $display("nearest_neighbor_match_counter test passed");
        end else begin
            $display("nearest_neighbor_match_counter test failed");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("nearest_neighbor_match_counter test failed");
        $finish;
    end

endmodule

[nearest_neighbor_match_counter.f]
design/nnmc_pkg.sv
design/nnmc_ram.sv
design/nnmc_dist.sv
design/nearest_neighbor_match_counter.sv
tb/sv/nearest_neighbor_match_counter_test.sv
